// ===== design/framed_byte_fifo_with_checksum_macros.svh =====
// Assertion macros for the framed byte FIFO.
// Used by the top level; it needs no other file.
`ifndef FRAMED_BYTE_FIFO_WITH_CHECKSUM_MACROS_SVH
`define FRAMED_BYTE_FIFO_WITH_CHECKSUM_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define FBFC_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, checked while out of reset.
`define FBFC_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== design/fbfc_pkg.sv =====
// Shared types and constants for the framed byte FIFO.
// No dependencies; fbfc_front, fbfc_back and the top level refer to it by scoped names.
`timescale 1ns / 1ps
package fbfc_pkg;

  localparam int BUFFER_DEPTH = 1024;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int LEN_W        = 16;
  localparam int BYTE_W       = 8;
  localparam int HDR_BYTES    = 4;
  localparam int SUM_BYTES    = 1;
  localparam int CMP_W        = ((LEN_W > CNT_W) ? LEN_W : CNT_W) + 1;
  localparam int S_TDATA_W    = 24;
  localparam int M_TDATA_W    = 56;

  typedef enum logic [1:0] {
    MODE_OPEN = 2'd0,
    MODE_DATA = 2'd1,
    MODE_POP  = 2'd2,
    MODE_NOP  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_OPEN,
    OP_DATA,
    OP_POP,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_SUM_ERR   = 3'd3,
    ST_NO_PUSH   = 3'd4,
    ST_PUSH_OPEN = 3'd5
  } status_e;

  // One classified item waiting for the sequencer.
  typedef struct packed {
    op_e               op;
    logic [LEN_W-1:0]  flen;
    logic [BYTE_W-1:0] dbyte;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [CNT_W-1:0]  bytes_used;
    logic [CNT_W-1:0]  frames_stored;
    logic              last;
    logic [LEN_W-1:0]  length_out;
    logic [BYTE_W-1:0] data_out;
    status_e           status;
  } result_t;

endpackage

// ===== design/fbfc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module fbfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/fbfc_front.sv =====
// Front end: accepts input items, classifies the mode and queues them.
// Depends on fbfc_pkg.
`timescale 1ns / 1ps
module fbfc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            mode_i,
  input  logic [fbfc_pkg::LEN_W-1:0]  flen_i,
  input  logic [fbfc_pkg::BYTE_W-1:0] dbyte_i,
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output fbfc_pkg::item_t       q_item_o
);

  fbfc_pkg::item_t slot_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  fbfc_pkg::item_t item_d;
  logic            push, pop;

  // Classify the mode into an operation.
  always_comb begin
    item_d.flen  = flen_i;
    item_d.dbyte = dbyte_i;
    case (fbfc_pkg::mode_e'(mode_i))
      fbfc_pkg::MODE_OPEN: item_d.op = fbfc_pkg::OP_OPEN;
      fbfc_pkg::MODE_DATA: item_d.op = fbfc_pkg::OP_DATA;
      fbfc_pkg::MODE_POP:  item_d.op = fbfc_pkg::OP_POP;
      default:             item_d.op = fbfc_pkg::OP_NOP;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rp_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  // Two-entry queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= item_d;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

// ===== design/fbfc_back.sv =====
// Back end: sequencer that writes and reads frames in the byte store.
// Depends on fbfc_pkg and fbfc_ram.
`timescale 1ns / 1ps
module fbfc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  fbfc_pkg::item_t q_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output fbfc_pkg::result_t out_res_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_WR, S_WSUM, S_RD, S_USE, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_HDR, PH_DATA, PH_SUM
  } phase_e;

  localparam int AW = fbfc_pkg::ADDR_W;
  localparam int CW = fbfc_pkg::CNT_W;
  localparam int LW = fbfc_pkg::LEN_W;
  localparam int BW = fbfc_pkg::BYTE_W;
  localparam int PW = fbfc_pkg::CMP_W;

  state_e  state_q;
  phase_e  phase_q;
  logic [1:0]    cnt_q;
  logic [AW-1:0] wr_idx_q, rd_idx_q;
  logic [CW-1:0] occ_q, frames_q;
  logic          push_open_q, pop_open_q;
  logic [LW-1:0] push_left_q, pop_left_q, pop_len_q, hlen_q;
  logic [BW-1:0] push_sum_q, pop_sum_q;
  fbfc_pkg::status_e st_q;
  logic [BW-1:0] dout_q;
  logic [LW-1:0] lout_q;
  logic          last_q;
  logic          out_valid_q;
  fbfc_pkg::result_t out_q;

  logic          we, re;
  logic [BW-1:0] wdata, rdata, hdr_byte;
  logic          start;
  logic          out_load;
  logic [PW-1:0] need, free;
  logic [LW-1:0] data_left, hlen_new;
  logic [BW-1:0] pop_sum_new;

  function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
    next_addr = (a == AW'(fbfc_pkg::BUFFER_DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  // Header byte for the current write step, big-endian length.
  always_comb begin
    case (cnt_q)
      2'd2:    hdr_byte = push_left_q[15:8];
      2'd3:    hdr_byte = push_left_q[7:0];
      default: hdr_byte = '0;
    endcase
  end

  // The next item may start while a finished result still waits; only the
  // load into the output register waits for it to be free.
  assign start     = (state_q == S_IDLE) && q_valid_i;
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign q_ready_o = start;
  assign need      = PW'(q_item_i.flen) + PW'(fbfc_pkg::HDR_BYTES + fbfc_pkg::SUM_BYTES);
  assign free      = PW'(fbfc_pkg::BUFFER_DEPTH) - PW'(occ_q);
  assign data_left = (push_left_q != '0) ? push_left_q - LW'(1) : '0;
  assign hlen_new  = {hlen_q[7:0], rdata};
  assign pop_sum_new = pop_sum_q + rdata;

  // Memory port controls.
  always_comb begin
    we    = 1'b0;
    wdata = q_item_i.dbyte;
    case (state_q)
      S_IDLE: we = start && (q_item_i.op == fbfc_pkg::OP_DATA) && push_open_q;
      S_WR: begin
        we    = 1'b1;
        wdata = hdr_byte;
      end
      S_WSUM: begin
        we    = 1'b1;
        wdata = push_sum_q;
      end
      default: we = 1'b0;
    endcase
  end
  assign re = (state_q == S_RD);

  fbfc_ram #(.WIDTH(BW), .DEPTH(fbfc_pkg::BUFFER_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_idx_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  // Sequencer state, bookkeeping and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_HDR;
      cnt_q       <= '0;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      occ_q       <= '0;
      frames_q    <= '0;
      push_open_q <= 1'b0;
      push_left_q <= '0;
      push_sum_q  <= '0;
      pop_open_q  <= 1'b0;
      pop_left_q  <= '0;
      pop_len_q   <= '0;
      pop_sum_q   <= '0;
      hlen_q      <= '0;
      st_q        <= fbfc_pkg::ST_OK;
      dout_q      <= '0;
      lout_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (we) begin
        wr_idx_q <= next_addr(wr_idx_q);
        occ_q    <= occ_q + CW'(1);
      end
      if (re) begin
        rd_idx_q <= next_addr(rd_idx_q);
        if (occ_q != '0) occ_q <= occ_q - CW'(1);
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            dout_q <= '0;
            last_q <= 1'b0;
            case (q_item_i.op)
              fbfc_pkg::OP_OPEN: begin
                lout_q <= '0;
                if (push_open_q) begin
                  st_q    <= fbfc_pkg::ST_PUSH_OPEN;
                  state_q <= S_DONE;
                end else if (need > free) begin
                  st_q    <= fbfc_pkg::ST_FULL;
                  state_q <= S_DONE;
                end else begin
                  st_q        <= fbfc_pkg::ST_OK;
                  push_sum_q  <= '0;
                  push_left_q <= q_item_i.flen;
                  cnt_q       <= '0;
                  state_q     <= S_WR;
                end
              end
              fbfc_pkg::OP_DATA: begin
                lout_q <= '0;
                if (!push_open_q) begin
                  st_q    <= fbfc_pkg::ST_NO_PUSH;
                  state_q <= S_DONE;
                end else begin
                  st_q        <= fbfc_pkg::ST_OK;
                  push_sum_q  <= push_sum_q + q_item_i.dbyte;
                  push_left_q <= data_left;
                  state_q     <= (data_left == '0) ? S_WSUM : S_DONE;
                end
              end
              fbfc_pkg::OP_POP: begin
                if (!pop_open_q && (frames_q == '0 || occ_q == '0)) begin
                  st_q    <= fbfc_pkg::ST_EMPTY;
                  lout_q  <= '0;
                  state_q <= S_DONE;
                end else if (!pop_open_q) begin
                  st_q      <= fbfc_pkg::ST_OK;
                  lout_q    <= '0;
                  phase_q   <= PH_HDR;
                  cnt_q     <= '0;
                  pop_sum_q <= '0;
                  hlen_q    <= '0;
                  state_q   <= S_RD;
                end else begin
                  st_q    <= fbfc_pkg::ST_OK;
                  lout_q  <= pop_len_q;
                  phase_q <= (pop_left_q == '0) ? PH_SUM : PH_DATA;
                  state_q <= S_RD;
                end
              end
              default: begin
                st_q    <= fbfc_pkg::ST_OK;
                lout_q  <= '0;
                state_q <= S_DONE;
              end
            endcase
          end
        end
        // Four header bytes, one per cycle.
        S_WR: begin
          push_sum_q <= push_sum_q + hdr_byte;
          cnt_q      <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            push_open_q <= 1'b1;
            state_q     <= (push_left_q == '0) ? S_WSUM : S_DONE;
          end
        end
        // Checksum byte closes the pushed frame.
        S_WSUM: begin
          frames_q    <= frames_q + CW'(1);
          push_open_q <= 1'b0;
          push_left_q <= '0;
          push_sum_q  <= '0;
          state_q     <= S_DONE;
        end
        S_RD: state_q <= S_USE;
        S_USE: begin
          case (phase_q)
            PH_HDR: begin
              pop_sum_q <= pop_sum_new;
              hlen_q    <= hlen_new;
              cnt_q     <= cnt_q + 2'd1;
              state_q   <= S_RD;
              if (cnt_q == 2'd3) begin
                pop_len_q  <= hlen_new;
                pop_left_q <= hlen_new;
                pop_open_q <= 1'b1;
                lout_q     <= hlen_new;
                phase_q    <= (hlen_new == '0) ? PH_SUM : PH_DATA;
              end
            end
            PH_DATA: begin
              pop_sum_q  <= pop_sum_new;
              dout_q     <= rdata;
              pop_left_q <= pop_left_q - LW'(1);
              if (pop_left_q == LW'(1)) begin
                phase_q <= PH_SUM;
                state_q <= S_RD;
              end else begin
                state_q <= S_DONE;
              end
            end
            default: begin
              last_q     <= 1'b1;
              st_q       <= (rdata == pop_sum_q) ? fbfc_pkg::ST_OK : fbfc_pkg::ST_SUM_ERR;
              if (frames_q != '0) frames_q <= frames_q - CW'(1);
              pop_open_q <= 1'b0;
              pop_left_q <= '0;
              pop_sum_q  <= '0;
              state_q    <= S_DONE;
            end
          endcase
        end
        // Load the result into the output register once it is free.
        S_DONE: begin
          if (out_load) begin
            out_q.status         <= st_q;
            out_q.data_out       <= dout_q;
            out_q.length_out     <= lout_q;
            out_q.last           <= last_q;
            out_q.frames_stored  <= frames_q;
            out_q.bytes_used     <= occ_q;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

// ===== design/framed_byte_fifo_with_checksum.sv =====
// Top level of the framed byte FIFO with additive checksum.
// Depends on fbfc_pkg, fbfc_front, fbfc_back and the assertion macro header.
//
//   channel | direction | tuser | tdata fields (low bit up)              | tlast
//   s_axis  | in        | mode  | frame_length, data_byte                | -
//   m_axis  | out       | -     | status, data_out, length_out,          | last_of_frame
//           |           |       | frames_stored, bytes_used              |
//
// Each item passes through the byte store sequencer in turn: a push open
// writes four header bytes (and the checksum for an empty frame), a closing
// data push the checksum too; pops read header, data and checksum bytes.
// Reset clears all pointers, counters and open-frame state; the store is not cleared.
// A two-entry queue keeps taking items while a result waits in the output register;
// the sequencer only stalls when it has a new result and the register is still full.
`timescale 1ns / 1ps
`include "framed_byte_fifo_with_checksum_macros.svh"
module framed_byte_fifo_with_checksum (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // mode[1:0]
  input  logic [1:0] s_axis_tuser_i,
  // frame_length[15:0], data_byte[23:16]
  input  logic [fbfc_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // status[2:0], data_out[10:3], length_out[26:11], frames_stored[37:27],
  // bytes_used[48:38], zero fill
  output logic [fbfc_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  output logic m_axis_tlast_o
);

  localparam int LW = fbfc_pkg::LEN_W;
  localparam int BW = fbfc_pkg::BYTE_W;

  logic              q_valid, q_ready;
  fbfc_pkg::item_t   q_item;
  fbfc_pkg::result_t res;

  fbfc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .mode_i     (s_axis_tuser_i),
    .flen_i     (s_axis_tdata_i[0 +: LW]),
    .dbyte_i    (s_axis_tdata_i[LW +: BW]),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  fbfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  // Pack the result item; the last flag travels on tlast.
  assign m_axis_tdata_o = fbfc_pkg::M_TDATA_W'({res.bytes_used, res.frames_stored,
                                               res.length_out, res.data_out, res.status});
  assign m_axis_tlast_o = res.last;

  `FBFC_ASSERT_IMPL(a_bytes_bounded, clk_i, rst_ni, m_axis_tvalid_o, res.bytes_used <= fbfc_pkg::CNT_W'(fbfc_pkg::BUFFER_DEPTH))
  `FBFC_ASSERT_IMPL(a_frames_need_bytes, clk_i, rst_ni, m_axis_tvalid_o, res.frames_stored == '0 || res.bytes_used != '0)
  `FBFC_ASSERT_IMPL(a_last_status, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tlast_o, res.status == fbfc_pkg::ST_OK || res.status == fbfc_pkg::ST_SUM_ERR)
  `FBFC_ASSERT_NEXT(a_hold_while_stalled, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))

endmodule
